FILE: rtl/core/integer_to_ascii_radix_macros.svh
// Assertion macros for the integer to ASCII radix converter.
// Expects clk and rst_n in the scope of the including module.
`ifndef INTEGER_TO_ASCII_RADIX_MACROS_SVH
`define INTEGER_TO_ASCII_RADIX_MACROS_SVH

// same-cycle implication
`define ITAR_ASSERT_IMP(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication
`define ITAR_ASSERT_NXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

FILE: rtl/core/itar_pkg.sv
// Package for the integer to ASCII radix converter: widths, ASCII codes
// and the digit to character mapping. No dependencies.
`default_nettype none

package itar_pkg;

    localparam int IN_VALUE_W  = 64;
    localparam int VALUE_BITS  = 64;
    localparam int MAX_DIGITS  = 64;
    localparam int STORE_DEPTH = 64;
    localparam int IDX_W       = $clog2(STORE_DEPTH);
    localparam int CNT_W       = IDX_W + 1;
    localparam int DIGIT_W     = 6;
    localparam int RADIX_W     = 6;
    localparam int CHAR_W      = 7;

    localparam int STEP_BITS   = 4;
    localparam int DIV_STEPS   = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
    localparam int QUO_W       = DIV_STEPS * STEP_BITS;
    localparam int STEP_CNT_W  = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

    localparam int EMIT_LIMIT  = (MAX_DIGITS > STORE_DEPTH) ? STORE_DEPTH : MAX_DIGITS;

    localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(36);
    localparam logic [DIGIT_W-1:0] DEC_BASE  = DIGIT_W'(10);

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = CHAR_W'(48);
    localparam logic [CHAR_W-1:0] CHAR_A     = CHAR_W'(97);
    localparam logic [CHAR_W-1:0] CHAR_MINUS = CHAR_W'(45);

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        if (d < DEC_BASE)
            return CHAR_ZERO + CHAR_W'(d);
        else
            return CHAR_A + CHAR_W'(d - DEC_BASE);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/integer_to_ascii_radix.sv
// Integer to ASCII converter, any radix 2..36, most significant digit first.
// Depends on itar_pkg and integer_to_ascii_radix_macros.svh.
//
//  channel | direction | handshake          | word
//  --------+-----------+--------------------+-----------------------------
//  in      | input     | in_valid/in_stall  | value, is_signed, radix
//  out     | output    | out_valid/out_stall| character, last
//
// Each digit takes a full pass over the quotient: the shared remainder unit divides 4 quotient bits
// a cycle. Each character then takes two steps (digit memory read, output load).
// in_stall is high from acceptance until the last character is loaded.
// out_stall holds the output register; the sequencer waits for it to drain.
// Reset clears the sequencer and output valid; the digit memory is not cleared.
`default_nettype none

`include "integer_to_ascii_radix_macros.svh"

module integer_to_ascii_radix
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [itar_pkg::IN_VALUE_W-1:0] value,
    input  wire logic                          is_signed,
    input  wire logic [itar_pkg::RADIX_W-1:0]  radix,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [itar_pkg::CHAR_W-1:0]        character,
    output logic                               last
);

    import itar_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SIGN,
        ST_READ,
        ST_PUT
    } state_t;

    state_t                  state_reg,  state_next;
    logic [QUO_W-1:0]        quo_reg,    quo_next;
    logic [RADIX_W-1:0]      rem_reg,    rem_next;
    logic [RADIX_W-1:0]      radix_reg,  radix_next;
    logic [STEP_CNT_W-1:0]   step_reg,   step_next;
    logic [CNT_W-1:0]        count_reg,  count_next;
    logic [CNT_W-1:0]        left_reg,   left_next;
    logic                    neg_reg,    neg_next;
    logic                    out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]       char_reg,   char_next;
    logic                    last_reg,   last_next;

    logic [DIGIT_W-1:0]      digit_mem [STORE_DEPTH];
    logic [DIGIT_W-1:0]      rd_data_reg;
    logic                    mem_we;
    logic [IDX_W-1:0]        mem_waddr;
    logic [IDX_W-1:0]        mem_raddr;

    logic                    out_free;
    logic [VALUE_BITS-1:0]   in_bits;
    logic                    in_neg;
    logic [VALUE_BITS-1:0]   in_mag;
    logic [RADIX_W-1:0]      in_radix;
    logic [QUO_W-1:0]        div_quo;
    logic [RADIX_W-1:0]      div_rem;
    logic [RADIX_W:0]        trial;
    logic [CNT_W-1:0]        count_inc;
    logic [CNT_W:0]          total_raw;
    logic [CNT_W-1:0]        total;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign character = char_reg;
    assign last      = last_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    assign in_bits  = value[VALUE_BITS-1:0];
    assign in_neg   = is_signed && in_bits[VALUE_BITS-1];
    assign in_mag   = in_neg ? (VALUE_BITS'(0) - in_bits) : in_bits;
    assign in_radix = (radix < RADIX_MIN) ? RADIX_MIN :
                      (radix > RADIX_MAX) ? RADIX_MAX : radix;

    assign mem_raddr = IDX_W'(count_reg - CNT_W'(1));
    assign mem_waddr = count_reg[IDX_W-1:0];
    assign count_inc = count_reg + CNT_W'(1);

    // shared remainder unit: STEP_BITS restoring steps on a narrow remainder
    always_comb
    begin
        div_quo = quo_reg;
        div_rem = rem_reg;
        trial   = '0;
        for (int i = 0; i < STEP_BITS; i++)
        begin
            trial   = {div_rem, div_quo[QUO_W-1]};
            div_quo = {div_quo[QUO_W-2:0], 1'b0};
            if (trial >= {1'b0, radix_reg})
            begin
                div_rem    = RADIX_W'(trial - {1'b0, radix_reg});
                div_quo[0] = 1'b1;
            end
            else
            begin
                div_rem = trial[RADIX_W-1:0];
            end
        end
    end

    assign total_raw = (CNT_W+1)'(neg_reg) + (CNT_W+1)'(count_inc);
    assign total     = (total_raw > (CNT_W+1)'(EMIT_LIMIT)) ? CNT_W'(EMIT_LIMIT)
                                                             : total_raw[CNT_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        radix_next     = radix_reg;
        step_next      = step_reg;
        count_next     = count_reg;
        left_next      = left_reg;
        neg_next       = neg_reg;
        out_valid_next = out_valid_reg && out_stall;
        char_next      = char_reg;
        last_next      = last_reg;
        mem_we         = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    quo_next   = QUO_W'(in_mag);
                    rem_next   = '0;
                    radix_next = in_radix;
                    step_next  = '0;
                    count_next = '0;
                    neg_next   = in_neg;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                quo_next  = div_quo;
                rem_next  = div_rem;
                step_next = step_reg + STEP_CNT_W'(1);
                if (step_reg == STEP_CNT_W'(DIV_STEPS - 1))
                begin
                    mem_we     = 1'b1;
                    count_next = count_inc;
                    rem_next   = '0;
                    step_next  = '0;
                    if (div_quo == '0 || count_inc >= CNT_W'(STORE_DEPTH))
                    begin
                        left_next  = total - CNT_W'(neg_reg);
                        state_next = neg_reg ? ST_SIGN : ST_READ;
                    end
                end
            end
            ST_SIGN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = CHAR_MINUS;
                    last_next      = (left_reg == '0);
                    state_next     = (left_reg == '0) ? ST_IDLE : ST_READ;
                end
            end
            ST_READ:
            begin
                count_next = count_reg - CNT_W'(1);
                state_next = ST_PUT;
            end
            ST_PUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = digit_char(rd_data_reg);
                    last_next      = (left_reg == CNT_W'(1));
                    left_next      = left_reg - CNT_W'(1);
                    state_next     = (left_reg == CNT_W'(1)) ? ST_IDLE : ST_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            digit_mem[mem_waddr] <= div_rem;
        if (state_reg == ST_READ)
            rd_data_reg <= digit_mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            quo_reg       <= '0;
            rem_reg       <= '0;
            radix_reg     <= RADIX_MIN;
            step_reg      <= '0;
            count_reg     <= '0;
            left_reg      <= '0;
            neg_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            char_reg      <= CHAR_ZERO;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            quo_reg       <= quo_next;
            rem_reg       <= rem_next;
            radix_reg     <= radix_next;
            step_reg      <= step_next;
            count_reg     <= count_next;
            left_reg      <= left_next;
            neg_reg       <= neg_next;
            out_valid_reg <= out_valid_next;
            char_reg      <= char_next;
            last_reg      <= last_next;
        end
    end

    `ITAR_ASSERT_NXT(a_accept_starts_div, in_valid && !in_stall, state_reg == ST_DIV, "accepted word did not start division")
    `ITAR_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CNT_W'(STORE_DEPTH), "digit count beyond store depth")
    `ITAR_ASSERT_IMP(a_rem_below_radix, state_reg == ST_DIV, rem_reg < radix_reg, "remainder not below radix")
    `ITAR_ASSERT_IMP(a_idle_nothing_left, state_reg == ST_IDLE && !in_valid, in_stall == 1'b0, "stalled while idle")

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench for integer_to_ascii_radix: directed table, then random numbers.
// Each accepted word is converted here, or taken from the directed table, and every character checked in order.
// Depends on itar_pkg and the integer_to_ascii_radix RTL.
`default_nettype none

module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import itar_pkg::*;

    localparam int  RANDOM_NUMS = 500;
    localparam int  HOLD_CYCLES = 3000;
    localparam int  SETTLE      = 64;
    // timeout bound sized from the slowest item (64 digits, 64 stalled characters) over ~525 items, times 5
    localparam longint CYCLE_LIMIT = 64'd6_000_000;
    localparam logic [63:0] MIN_NEG = 64'h8000_0000_0000_0000;
    localparam logic [63:0] ALL_ONES = '1;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              fin;
    } char_word_t;

    typedef struct packed {
        logic [63:0]        val;
        logic               sgn;
        logic [RADIX_W-1:0] rad;
    } num_word_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [IN_VALUE_W-1:0] value;
    logic                is_signed;
    logic [RADIX_W-1:0]  radix;
    logic                out_valid;
    logic                out_stall;
    logic [CHAR_W-1:0]   character;
    logic                last;

    char_word_t  char_q[$];
    num_word_t   dir_rows[$];
    string       dir_text[$];
    int          errors;
    int          nums_sent;
    int          negs_sent;
    int          clamped_sent;
    int          chars_checked;
    longint      cycles;
    logic        calm;
    logic        hold_req;

    integer_to_ascii_radix u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .value     (value),
        .is_signed (is_signed),
        .radix     (radix),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .character (character),
        .last      (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d characters outstanding",
                     cycles, char_q.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        errors++;
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
        if (d < 10)
            return CHAR_ZERO + CHAR_W'(d);
        return CHAR_A + CHAR_W'(d - 10);
    endfunction

    // Queue the characters of one number, sign first, most significant digit next
    function automatic void predict_text(input logic [63:0] v, input logic sgn,
                                         input logic [RADIX_W-1:0] rad);
        logic [63:0]        mag;
        logic [63:0]        base;
        logic [DIGIT_W-1:0] digs [64];
        logic               neg;
        int                 n;
        int                 total;
        int                 k;
        int                 emitted;
        char_word_t         w;
        base = (rad < RADIX_MIN) ? 64'(RADIX_MIN) : (rad > RADIX_MAX) ? 64'(RADIX_MAX) : 64'(rad);
        neg = sgn && v[63];
        mag = neg ? (64'd0 - v) : v;
        n = 0;
        do
        begin
            digs[n] = DIGIT_W'(mag % base);
            n++;
            mag = mag / base;
        end
        while (mag != 0 && n < 64);
        total = int'(neg) + n;
        if (total > EMIT_LIMIT)
            total = EMIT_LIMIT;
        emitted = 0;
        if (neg)
        begin
            w.ch = CHAR_MINUS;
            w.fin = (total == 1);
            char_q.push_back(w);
            emitted++;
        end
        k = n;
        while (emitted < total && k > 0)
        begin
            k--;
            emitted++;
            w.ch = digit_to_ascii(digs[k]);
            w.fin = (emitted == total);
            char_q.push_back(w);
        end
    endfunction

    function automatic void queue_text(input string s);
        char_word_t w;
        for (int i = 0; i < s.len(); i++)
        begin
            w.ch = CHAR_W'(s[i]);
            w.fin = (i == s.len() - 1);
            char_q.push_back(w);
        end
    endfunction

    task automatic send_num(input logic [63:0] v, input logic s,
                            input logic [RADIX_W-1:0] r, input string known);
        int gap;
        gap = calm ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16));
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        value     <= v;
        is_signed <= s;
        radix     <= r;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        // word taken at this edge
        if (known.len() > 0)
            queue_text(known);
        else
            predict_text(v, s, r);
        nums_sent++;
        if (s && v[63])
            negs_sent++;
        if (r < RADIX_MIN || r > RADIX_MAX)
            clamped_sent++;
    endtask

    function automatic num_word_t draw_num();
        num_word_t  w;
        logic [63:0] raw;
        int         pick;
        raw = {$urandom, $urandom};
        pick = $urandom_range(0, 9);
        case (pick)
            0, 1, 2, 3: w.val = raw;
            4, 5, 6:    w.val = raw >> $urandom_range(1, 63);
            7:          w.val = 64'd0 - (raw >> $urandom_range(1, 63));
            8:
            begin
                case ($urandom_range(0, 5))
                    0: w.val = 64'd0;
                    1: w.val = 64'd1;
                    2: w.val = MIN_NEG;
                    3: w.val = ~MIN_NEG;
                    4: w.val = ALL_ONES;
                    default: w.val = MIN_NEG + 64'd1;
                endcase
            end
            default:    w.val = 64'd1 << $urandom_range(0, 63);
        endcase
        w.sgn = 1'($urandom);
        pick = $urandom_range(0, 19);
        if (pick < 17)
            w.rad = RADIX_W'($urandom_range(2, 36));
        else if (pick < 19)
            w.rad = RADIX_W'($urandom_range(0, 63));
        else
            w.rad = ($urandom_range(0, 1) == 1) ? RADIX_W'(16) : RADIX_W'(10);
        return w;
    endfunction

    task automatic add_row(input logic [63:0] v, input logic s, input int r, input string t);
        num_word_t w;
        w.val = v;
        w.sgn = s;
        w.rad = RADIX_W'(r);
        dir_rows.push_back(w);
        dir_text.push_back(t);
    endtask

    // receiving side: random stalls, calm stretches and one long hold-off
    initial
    begin : receiver
        int n;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                n = calm ? 0 : (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 16));
                if (n > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (n) @(posedge clk);
                end
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin : out_check
        char_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (char_q.size() == 0)
                report_mismatch($sformatf("unexpected character %0d last %0b", character, last));
            else
            begin
                want = char_q.pop_front();
                chars_checked++;
                if (character !== want.ch)
                    report_mismatch($sformatf("character %0d, wanted %0d", character, want.ch));
                if (last !== want.fin)
                    report_mismatch($sformatf("last %0b, wanted %0b (character %0d)",
                                              last, want.fin, want.ch));
            end
        end
    end

    initial
    begin : sender
        num_word_t w;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        value     = '0;
        is_signed = 1'b0;
        radix     = RADIX_W'(10);
        errors    = 0;
        nums_sent = 0;
        negs_sent = 0;
        clamped_sent = 0;
        chars_checked = 0;
        cycles    = 0;
        calm      = 1'b0;
        hold_req  = 1'b0;

        add_row(64'd0, 1'b0, 10, "0");
        add_row(64'd0, 1'b1, 2, "0");
        add_row(64'd1, 1'b0, 2, "1");
        add_row(ALL_ONES, 1'b0, 16, "ffffffffffffffff");
        add_row(ALL_ONES, 1'b1, 10, "-1");
        add_row(ALL_ONES, 1'b0, 10, "18446744073709551615");
        add_row(ALL_ONES, 1'b0, 2, "");
        add_row(ALL_ONES, 1'b0, 36, "");
        add_row(MIN_NEG, 1'b1, 10, "-9223372036854775808");
        add_row(MIN_NEG, 1'b1, 16, "-8000000000000000");
        add_row(MIN_NEG, 1'b1, 2, "");
        add_row(MIN_NEG, 1'b0, 2, "");
        add_row(~MIN_NEG, 1'b1, 10, "9223372036854775807");
        add_row(64'd35, 1'b0, 36, "z");
        add_row(64'd10, 1'b0, 11, "a");
        add_row(64'd255, 1'b0, 0, "11111111");
        add_row(64'd5, 1'b1, 1, "101");
        add_row(64'd35, 1'b0, 63, "z");
        add_row(64'd36, 1'b0, 37, "10");
        add_row(64'd0 - 64'd255, 1'b1, 16, "-ff");
        add_row(64'h1234_5678_9abc_def0, 1'b0, 16, "123456789abcdef0");
        add_row(64'hffff_ffff_8000_0000, 1'b1, 10, "-2147483648");
        add_row(64'h0000_0000_8000_0000, 1'b1, 10, "2147483648");
        add_row(64'd1000, 1'b1, 10, "1000");

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_num(dir_rows[i].val, dir_rows[i].sgn, dir_rows[i].rad, dir_text[i]);

        for (int i = 0; i < RANDOM_NUMS; i++)
        begin
            if (i == 150)
                hold_req = 1'b1;
            if (i == 300)
            begin
                // drain fully before carrying on
                in_valid <= 1'b0;
                @(posedge clk);
                while (char_q.size() != 0)
                    @(posedge clk);
            end
            calm = (i >= 400 && i < 450);
            w = draw_num();
            send_num(w.val, w.sgn, w.rad, "");
        end
        in_valid <= 1'b0;
        calm = 1'b0;

        while (char_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        $display("%0d numbers converted (%0d negative signed, %0d radix clamped), %0d characters",
                 nums_sent, negs_sent, clamped_sent, chars_checked);
        $display("long output hold-off and full drain pause both exercised, %0d mismatches",
                 errors);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
